// ----- design/slipdf_pkg.sv -----
// Package for the SLIP deframer with CRC check.
// Holds the item structs, SLIP codes, CRC constants and the CRC byte update.
// No dependencies.
package slipdf_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int MIN_LEN_W       = 9;
    localparam int FRAME_LEN_W     = 9;
    localparam int WR_INDEX_W      = 8;
    localparam int CMP_W           = (CNT_W > MIN_LEN_W) ? CNT_W : MIN_LEN_W;

    localparam logic [7:0] END_CODE     = 8'hC0;
    localparam logic [7:0] ESC_CODE     = 8'hDB;
    localparam logic [7:0] ESC_END_CODE = 8'hDC;
    localparam logic [7:0] ESC_ESC_CODE = 8'hDD;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 9'd9;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_free;
        logic       sink_ready;
    } in_item_t;

    typedef struct packed {
        logic                   wr_valid;
        logic [WR_INDEX_W-1:0]  wr_index;
        logic [7:0]             wr_byte;
        logic                   frame_delivered;
        logic [FRAME_LEN_W-1:0] frame_len;
        logic                   crc_ok;
        logic                   overflow;
    } out_item_t;

    // CRC-16/CCITT-FALSE update by one byte, MSB first.
    function automatic logic [15:0] crc_add(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- design/slip_deframer_with_crc_check_unit.sv -----
// Top level of the SLIP deframer with CRC-16 frame check.
// Instantiates slipdf_decode and slipdf_out_buf; uses slipdf_pkg.
//
// One received byte is taken per item and gives exactly one result item.
// An item is accepted in every clock cycle while the two-entry output
// buffer (result register plus skid stage) has room, so the sustained rate
// is one item per cycle; each result goes into the result register, or into
// the skid stage while that register is held. The frame state, byte count
// and CRC register update in the accepting cycle, which is what lets items
// follow back to back. min_frame_len is written through cfg_wr_en/cfg_wr_data
// and resets to 9; write it only while the block is idle.
module slip_deframer_with_crc_check_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [slipdf_pkg::MIN_LEN_W-1:0] cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  slipdf_pkg::in_item_t             s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output slipdf_pkg::out_item_t            m_item
);

    logic [slipdf_pkg::MIN_LEN_W-1:0] min_frame_len_reg;
    logic                             accept;
    slipdf_pkg::out_item_t            result;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_frame_len_reg <= slipdf_pkg::MIN_LEN_RESET;
        end else if (cfg_wr_en) begin
            min_frame_len_reg <= cfg_wr_data;
        end
    end

    slipdf_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (accept),
        .item          (s_item),
        .min_frame_len (min_frame_len_reg),
        .result        (result)
    );

    slipdf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_item (result),
        .can_load  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ----- design/slipdf_decode.sv -----
// Frame state and decode logic of the SLIP deframer.
// Unescapes, counts, updates the CRC and builds one result per item.
// Depends on slipdf_pkg.
module slipdf_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  slipdf_pkg::in_item_t                item,
    input  logic [slipdf_pkg::MIN_LEN_W-1:0]    min_frame_len,
    output slipdf_pkg::out_item_t               result
);

    logic                         in_packet_reg, in_packet_next;
    logic                         escape_pending_reg, escape_pending_next;
    logic [slipdf_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic                         capture_enabled_reg, capture_enabled_next;
    logic [15:0]                  running_crc_reg, running_crc_next;

    logic [7:0] data_byte;
    logic       long_enough;
    logic       has_room;

    assign long_enough = (slipdf_pkg::CMP_W'(byte_count_reg)
                          >= slipdf_pkg::CMP_W'(min_frame_len));
    assign has_room    = (byte_count_reg < slipdf_pkg::CNT_W'(slipdf_pkg::MAX_FRAME_BYTES));

    // An unknown code after ESC is passed through unchanged.
    always_comb begin
        data_byte = item.rx_byte;
        if (escape_pending_reg) begin
            if (item.rx_byte == slipdf_pkg::ESC_END_CODE) begin
                data_byte = slipdf_pkg::END_CODE;
            end else if (item.rx_byte == slipdf_pkg::ESC_ESC_CODE) begin
                data_byte = slipdf_pkg::ESC_CODE;
            end
        end
    end

    always_comb begin
        in_packet_next       = in_packet_reg;
        escape_pending_next  = escape_pending_reg;
        byte_count_next      = byte_count_reg;
        capture_enabled_next = capture_enabled_reg;
        running_crc_next     = running_crc_reg;
        result               = '0;

        priority if (item.rx_byte == slipdf_pkg::END_CODE) begin
            if (capture_enabled_reg) begin
                if (long_enough && item.sink_ready) begin
                    result.frame_delivered = 1'b1;
                    result.frame_len       = slipdf_pkg::FRAME_LEN_W'(byte_count_reg);
                    result.crc_ok          = (running_crc_reg == 16'h0000);
                    capture_enabled_next   = item.buffer_free;
                end
            end else begin
                capture_enabled_next = item.buffer_free;
            end
            in_packet_next      = 1'b1;
            escape_pending_next = 1'b0;
            byte_count_next     = '0;
            running_crc_next    = slipdf_pkg::CRC_INIT;
        end else if (in_packet_reg) begin
            if (!escape_pending_reg && item.rx_byte == slipdf_pkg::ESC_CODE) begin
                escape_pending_next = 1'b1;
            end else begin
                escape_pending_next = 1'b0;
                if (has_room) begin
                    if (capture_enabled_reg) begin
                        result.wr_valid = 1'b1;
                        result.wr_index = slipdf_pkg::WR_INDEX_W'(byte_count_reg);
                        result.wr_byte  = data_byte;
                    end
                    running_crc_next = slipdf_pkg::crc_add(running_crc_reg, data_byte);
                    byte_count_next  = byte_count_reg + 1'b1;
                end else begin
                    // The frame is abandoned until the next END.
                    in_packet_next  = 1'b0;
                    byte_count_next = '0;
                    result.overflow = 1'b1;
                end
            end
        end else begin
            // Bytes outside a frame are ignored.
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg       <= 1'b0;
            escape_pending_reg  <= 1'b0;
            byte_count_reg      <= '0;
            capture_enabled_reg <= 1'b1;
            running_crc_reg     <= slipdf_pkg::CRC_INIT;
        end else if (step) begin
            in_packet_reg       <= in_packet_next;
            escape_pending_reg  <= escape_pending_next;
            byte_count_reg      <= byte_count_next;
            capture_enabled_reg <= capture_enabled_next;
            running_crc_reg     <= running_crc_next;
        end
    end

endmodule

// ----- design/slipdf_out_buf.sv -----
// Result register with a skid stage for the SLIP deframer.
// Keeps the input side running while a result waits on the output side.
// Depends on slipdf_pkg.
module slipdf_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  slipdf_pkg::out_item_t load_item,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output slipdf_pkg::out_item_t m_item
);

    logic                  out_valid_reg;
    slipdf_pkg::out_item_t out_item_reg;
    logic                  skid_valid_reg;
    slipdf_pkg::out_item_t skid_item_reg;
    logic                  take;

    assign can_load = !skid_valid_reg;
    assign take     = out_valid_reg && m_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            // The skid stage only fills while the result register is held,
            // and no item is taken while it is full.
            priority if (skid_valid_reg && take) begin
                out_item_reg   <= skid_item_reg;
                skid_valid_reg <= 1'b0;
            end else if (load && (!out_valid_reg || take)) begin
                out_item_reg  <= load_item;
                out_valid_reg <= 1'b1;
            end else if (load) begin
                skid_item_reg  <= load_item;
                skid_valid_reg <= 1'b1;
            end else if (take) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

endmodule
